// ----- rtl/core/wtlp_pkg.sv -----
// ----------------------------------------------------------------------------
// wtlp_pkg
// Shared types and constants of the worker table least-load picker.
// ----------------------------------------------------------------------------
`default_nettype none

package wtlp_pkg;

  localparam int unsigned Slots     = 16;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam logic [31:0] TimeoutRst = 32'd30;
  localparam logic [31:0] AgeMax     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_HBEAT = 3'd1,
    REQ_LOAD  = 3'd2,
    REQ_DEAD  = 3'd3,
    REQ_QUERY = 3'd4,
    REQ_PICK  = 3'd5,
    REQ_SCAN  = 3'd6,
    REQ_TICK  = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPLY,
    ST_EMIT,
    ST_SCAN_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] worker_id;
    logic [15:0] running_count;
    logic [15:0] queued_count;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] result_id;
    logic [16:0] result_load;
    logic        result_alive;
    logic        last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request, clear walk state
    logic step;       // examine current slot, advance pointer
    logic apply;      // commit the request's update and build response
    logic load_scan;  // build scan response for the current slot
    logic scan_next;  // advance scan pointer
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic   walk_done;  // pointer on last slot
    logic   is_scan;
    logic   scan_hit;   // current scan slot timed out
    logic   scan_any;   // at least one timed out slot found
    logic   scan_done;  // scan pointer on last slot
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/wtlp_datapath.sv -----
// ----------------------------------------------------------------------------
// wtlp_datapath
// Slot table, one-slot-per-cycle walk, update and response building.
// ----------------------------------------------------------------------------
`default_nettype none

module wtlp_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wtlp_pkg::req_t      req_i,
  input  wire  [31:0]         timeout_i,
  input  wtlp_pkg::dp_cmd_t   cmd_i,
  output wtlp_pkg::dp_sts_t   sts_o,
  output wtlp_pkg::rsp_t      rsp_o
);
  import wtlp_pkg::*;

  logic [Slots-1:0] valid_q;
  logic [15:0]      id_q    [Slots];
  logic [15:0]      run_q   [Slots];
  logic [15:0]      que_q   [Slots];
  logic [Slots-1:0] alive_q;
  logic [31:0]      age_q   [Slots];
  logic [Slots-1:0] tout_q;   // timed-out marks, captured during the walk

  req_t             req_q;
  logic [SlotW-1:0] ptr_q;
  logic             found_q, free_q, best_q;
  logic [SlotW-1:0] hit_q, free_s_q, best_s_q;
  logic [16:0]      best_load_q;
  logic [15:0]      best_id_q;
  rsp_t             rsp_q, rsp_d;

  logic [16:0] cur_load;
  logic        better;
  logic [SlotW-1:0] last_slot;

  assign last_slot = SlotW'(Slots - 1);
  assign cur_load  = {1'b0, run_q[ptr_q]} + {1'b0, que_q[ptr_q]};
  assign better    = !best_q || (cur_load < best_load_q) ||
                     (cur_load == best_load_q && id_q[ptr_q] < best_id_q);

  // status to the controller
  always_comb begin
    sts_o.walk_done = (ptr_q == last_slot);
    sts_o.is_scan   = (req_q.req_type == REQ_SCAN);
    sts_o.scan_hit  = tout_q[ptr_q];
    sts_o.scan_any  = |tout_q;
    sts_o.scan_done = (ptr_q == last_slot);
  end

  assign rsp_o = rsp_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.apply && req_q.req_type == REQ_ADD && !found_q && free_q) begin
      valid_q[free_s_q] <= 1'b1;
    end
  end

  // walk: lookup, free slot, pick and timeout marks
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_i;
      ptr_q   <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      best_q  <= 1'b0;
      hit_q   <= '0;
      free_s_q <= '0;
      best_s_q <= '0;
      best_load_q <= '0;
      best_id_q <= '0;
    end else if (cmd_i.step) begin
      if (!sts_o.walk_done) ptr_q <= ptr_q + 1'b1;
      else ptr_q <= '0;
      tout_q[ptr_q] <= valid_q[ptr_q] && (age_q[ptr_q] > timeout_i);
      if (valid_q[ptr_q] && id_q[ptr_q] == req_q.worker_id && !found_q) begin
        found_q <= 1'b1;
        hit_q   <= ptr_q;
      end
      if (!valid_q[ptr_q] && !free_q) begin
        free_q   <= 1'b1;
        free_s_q <= ptr_q;
      end
      if (valid_q[ptr_q] && alive_q[ptr_q] && better) begin
        best_q      <= 1'b1;
        best_s_q    <= ptr_q;
        best_load_q <= cur_load;
        best_id_q   <= id_q[ptr_q];
      end
    end else if (cmd_i.scan_next) begin
      ptr_q <= ptr_q + 1'b1;
    end
  end

  // table update
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      unique case (req_q.req_type)
        REQ_ADD: begin
          if (!found_q && free_q) begin
            id_q[free_s_q]    <= req_q.worker_id;
            run_q[free_s_q]   <= '0;
            que_q[free_s_q]   <= '0;
            alive_q[free_s_q] <= 1'b1;
            age_q[free_s_q]   <= '0;
          end
        end
        REQ_HBEAT, REQ_LOAD, REQ_DEAD, REQ_QUERY: begin
          if (found_q) begin
            case (req_q.req_type)
              REQ_HBEAT: age_q[hit_q] <= '0;
              REQ_LOAD: begin
                run_q[hit_q] <= req_q.running_count;
                que_q[hit_q] <= req_q.queued_count;
              end
              REQ_DEAD: alive_q[hit_q] <= 1'b0;
              default: ;
            endcase
          end
        end
        REQ_TICK: begin
          for (int s = 0; s < Slots; s++) begin
            if (valid_q[s] && age_q[s] != AgeMax) age_q[s] <= age_q[s] + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // response building
  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.apply) begin
      rsp_d = '0;
      rsp_d.last = 1'b1;
      unique case (req_q.req_type)
        REQ_ADD: begin
          if (!found_q && free_q) begin
            rsp_d.ok           = 1'b1;
            rsp_d.result_id    = req_q.worker_id;
            rsp_d.result_alive = 1'b1;
          end
        end
        REQ_HBEAT, REQ_LOAD, REQ_DEAD, REQ_QUERY: begin
          if (found_q) begin
            rsp_d.ok           = 1'b1;
            rsp_d.result_id    = id_q[hit_q];
            rsp_d.result_alive = alive_q[hit_q];
            rsp_d.result_load  = {1'b0, run_q[hit_q]} + {1'b0, que_q[hit_q]};
            case (req_q.req_type)
              REQ_LOAD: rsp_d.result_load = {1'b0, req_q.running_count} +
                                            {1'b0, req_q.queued_count};
              REQ_DEAD: rsp_d.result_alive = 1'b0;
              default: ;
            endcase
          end
        end
        REQ_PICK: begin
          if (best_q) begin
            rsp_d.ok           = 1'b1;
            rsp_d.result_id    = best_id_q;
            rsp_d.result_load  = best_load_q;
            rsp_d.result_alive = 1'b1;
          end
        end
        REQ_TICK: rsp_d.ok = 1'b1;
        default: ;  // scan with no hit: all zero, last set
      endcase
    end else if (cmd_i.load_scan) begin
      rsp_d.ok           = 1'b1;
      rsp_d.result_id    = id_q[ptr_q];
      rsp_d.result_load  = cur_load;
      rsp_d.result_alive = alive_q[ptr_q];
      rsp_d.last         = ((tout_q >> ptr_q) >> 1) == '0;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wtlp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtlp_ctrl
// Request sequencer: walk, apply, and emit one or several responses.
// ----------------------------------------------------------------------------
`default_nettype none

module wtlp_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  wire                rsp_ready_i,
  input  wtlp_pkg::dp_sts_t  sts_i,
  output wtlp_pkg::dp_cmd_t  cmd_o
);
  import wtlp_pkg::*;

  state_e state_q, state_d;
  logic   vld_q, vld_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  assign rsp_valid_o = vld_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_done) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts_i.is_scan && sts_i.scan_any) begin
          state_d = ST_SCAN_OUT;
        end else begin
          cmd_o.apply = 1'b1;
          vld_d   = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rsp_ready_i) begin
          vld_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_OUT: begin
        if (vld_q) begin
          if (rsp_ready_i) begin
            vld_d = 1'b0;
            if (sts_i.scan_done) state_d = ST_IDLE;
            else cmd_o.scan_next = 1'b1;
          end
        end else if (sts_i.scan_hit) begin
          cmd_o.load_scan = 1'b1;
          vld_d = 1'b1;
        end else if (sts_i.scan_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/worker_table_least_load_picker.sv -----
// ----------------------------------------------------------------------------
// worker_table_least_load_picker
// Worker table with least-load pick, timeout scan and heartbeat aging.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_i (req_t)
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_o (rsp_t)
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_data_i (heartbeat timeout)
//
//  every request walks all slots, one per cycle, then is applied and answered;
//  a timeout scan then revisits the slots in order to emit each timed out one, held until taken.
//  reset clears the valid flags and sets the timeout to 30.
//  the request port is held off until the last response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module worker_table_least_load_picker (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              req_valid,
  output logic             req_ready,
  input  wtlp_pkg::req_t   req_i,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output wtlp_pkg::rsp_t   rsp_o,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [31:0]      cfg_data_i
);
  import wtlp_pkg::*;

  logic [31:0] timeout_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign cfg_ready = 1'b1;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (cfg_valid) begin
      timeout_q <= cfg_data_i;
    end
  end

  wtlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wtlp_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .timeout_i (timeout_q),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire

// ----- tb/worker_table_least_load_picker_tb.sv -----
// ----------------------------------------------------------------------------
// worker_table_least_load_picker_tb
// Self-checking bench for the worker table: random and directed requests
// against an in-bench table predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module worker_table_least_load_picker_tb;
  import wtlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 16;
  localparam int MaxRsp = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_i = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data_i = '0;

  worker_table_least_load_picker uut (
    .clk_i, .rst_ni, .req_valid, .req_ready, .req_i,
    .rsp_valid, .rsp_ready, .rsp_o, .cfg_valid, .cfg_ready, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // predicted table state
  logic        tbl_valid [NumSlots];
  logic [15:0] tbl_id    [NumSlots];
  logic [15:0] tbl_run   [NumSlots];
  logic [15:0] tbl_que   [NumSlots];
  logic        tbl_alive [NumSlots];
  logic [31:0] tbl_age   [NumSlots];
  logic [31:0] timeout_val = TimeoutRst;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   rsp_count = 0;
  int   req_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  // append to the expected response queue
  function automatic void add_rsp(input rsp_t r);
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  // append to the pending request queue
  function automatic void add_req(input req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic rsp_t slot_rsp(int s, logic lst);
    rsp_t r;
    r = '0;
    r.last = lst;
    if (s >= 0) begin
      r.ok = 1'b1;
      r.result_id = tbl_id[s];
      r.result_load = {1'b0, tbl_run[s]} + {1'b0, tbl_que[s]};
      r.result_alive = tbl_alive[s];
    end
    return r;
  endfunction

  // apply one request to the table and queue its responses
  task automatic predict_table(input req_t rq);
    int s, hit, best, k;
    logic [16:0] bl, ld;
    rsp_t r;
    hit = -1;
    for (s = 0; s < NumSlots; s++)
      if (hit < 0 && tbl_valid[s] && tbl_id[s] == rq.worker_id) hit = s;
    case (req_e'(rq.req_type))
      REQ_ADD: begin
        best = -1;
        for (s = NumSlots - 1; s >= 0; s--) if (!tbl_valid[s]) best = s;
        if (hit >= 0 || best < 0) begin
          add_rsp(slot_rsp(-1, 1'b1));
        end else begin
          tbl_valid[best] = 1'b1; tbl_id[best] = rq.worker_id;
          tbl_run[best] = '0; tbl_que[best] = '0;
          tbl_alive[best] = 1'b1; tbl_age[best] = '0;
          add_rsp(slot_rsp(best, 1'b1));
        end
      end
      REQ_HBEAT, REQ_LOAD, REQ_DEAD, REQ_QUERY: begin
        if (hit >= 0) begin
          if (rq.req_type == REQ_HBEAT) tbl_age[hit] = '0;
          else if (rq.req_type == REQ_LOAD) begin
            tbl_run[hit] = rq.running_count; tbl_que[hit] = rq.queued_count;
          end else if (rq.req_type == REQ_DEAD) tbl_alive[hit] = 1'b0;
        end
        add_rsp(slot_rsp(hit, 1'b1));
      end
      REQ_PICK: begin
        best = -1; bl = '0;
        for (s = 0; s < NumSlots; s++) begin
          if (tbl_valid[s] && tbl_alive[s]) begin
            ld = {1'b0, tbl_run[s]} + {1'b0, tbl_que[s]};
            if (best < 0 || ld < bl || (ld == bl && tbl_id[s] < tbl_id[best])) begin
              best = s; bl = ld;
            end
          end
        end
        add_rsp(slot_rsp(best, 1'b1));
      end
      REQ_SCAN: begin
        k = 0; best = -1;
        for (s = 0; s < NumSlots; s++)
          if (k < MaxRsp && tbl_valid[s] && tbl_age[s] > timeout_val) begin
            k++; best = s;
          end
        if (k == 0) add_rsp(slot_rsp(-1, 1'b1));
        else
          for (s = 0; s <= best; s++)
            if (tbl_valid[s] && tbl_age[s] > timeout_val)
              add_rsp(slot_rsp(s, s == best));
      end
      default: begin
        for (s = 0; s < NumSlots; s++)
          if (tbl_valid[s] && tbl_age[s] != AgeMax) tbl_age[s]++;
        r = '0; r.ok = 1'b1; r.last = 1'b1;
        add_rsp(r);
      end
    endcase
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid && req_ready) begin
        predict_table(req_i);
        req_count++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_i <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and ready generation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response %p", rsp_o);
        end else if (rsp_o !== expected_rsps[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p actual %p", expected_rsps[0], rsp_o);
          void'(expected_rsps.pop_front());
        end else begin
          void'(expected_rsps.pop_front());
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic req_t mk_req(req_e t, logic [15:0] id,
                                  logic [15:0] rc = '0, logic [15:0] qc = '0);
    req_t r;
    r.req_type = t; r.worker_id = id; r.running_count = rc; r.queued_count = qc;
    return r;
  endfunction

  // sample between edges so every driver update has settled
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || !req_ready ||
           expected_rsps.size() > 0)
      @(negedge clk_i);
    repeat (NumSlots + 8) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    timeout_val = v;
  endtask

  // random phase: mostly ids from a small pool so lookups hit
  task automatic queue_random(input int n);
    int i, sel;
    logic [15:0] id;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(19));
      if (sel < 18) add_req(mk_req(REQ_ADD, id));
      else if (sel < 28) add_req(mk_req(REQ_HBEAT, id));
      else if (sel < 43)
        add_req(mk_req(REQ_LOAD, id,
          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5)),
          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5))));
      else if (sel < 50) add_req(mk_req(REQ_DEAD, id));
      else if (sel < 57) add_req(mk_req(REQ_QUERY, id));
      else if (sel < 70) add_req(mk_req(REQ_PICK, id));
      else if (sel < 80) add_req(mk_req(REQ_SCAN, 16'($urandom)));
      else add_req(req_t'({REQ_TICK, 16'($urandom), 16'($urandom),
                           16'($urandom)}));
    end
  endtask

  initial begin
    int p;
    for (p = 0; p < NumSlots; p++) begin
      tbl_valid[p] = 1'b0; tbl_id[p] = '0; tbl_run[p] = '0;
      tbl_que[p] = '0; tbl_alive[p] = 1'b0; tbl_age[p] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table cases, extremes, full table, duplicates, scan
    add_req(mk_req(REQ_PICK, 16'h0));
    add_req(mk_req(REQ_SCAN, 16'h0));
    add_req(mk_req(REQ_QUERY, 16'hFFFF));
    add_req(mk_req(REQ_ADD, 16'hFFFF));
    add_req(mk_req(REQ_ADD, 16'hFFFF));
    add_req(mk_req(REQ_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_req(mk_req(REQ_ADD, 16'h0));
    add_req(mk_req(REQ_PICK, 16'h0));
    add_req(mk_req(REQ_TICK, 16'h0));
    add_req(mk_req(REQ_HBEAT, 16'h0));
    add_req(mk_req(REQ_HBEAT, 16'h1234));
    add_req(mk_req(REQ_DEAD, 16'h0));
    add_req(mk_req(REQ_DEAD, 16'h5555));
    add_req(mk_req(REQ_PICK, 16'h0));
    for (p = 2; p < 17; p++) add_req(mk_req(REQ_ADD, 16'(p * 1000)));
    add_req(mk_req(REQ_PICK, 16'h0));
    wait_drained();

    // short timeout: tick past it so a scan reports a full table
    write_timeout(32'd1);
    repeat (3) add_req(mk_req(REQ_TICK, 16'h0));
    add_req(mk_req(REQ_SCAN, 16'h0));
    add_req(mk_req(REQ_HBEAT, 16'd2000));
    add_req(mk_req(REQ_SCAN, 16'h0));
    wait_drained();
    write_timeout(32'hFFFF_FFFF);
    add_req(mk_req(REQ_SCAN, 16'h0));
    for (p = 2; p < 17; p++) add_req(mk_req(REQ_DEAD, 16'(p * 1000)));
    add_req(mk_req(REQ_PICK, 16'h0));
    wait_drained();

    // random phases; the table stays full so random adds fail
    write_timeout(32'd3);
    queue_random(75);
    wait_drained();
    write_timeout(32'd1);
    send_idle_pct = 70;
    queue_random(75);
    wait_drained();
    write_timeout(32'd8);
    send_idle_pct = 0; recv_stall_pct = 70;
    queue_random(75);
    wait_drained();
    write_timeout(TimeoutRst);
    send_idle_pct = 8; recv_stall_pct = 8;
    queue_random(70);
    wait_drained();

    $display("covered %0d requests and %0d responses over several timeout settings",
             req_count, rsp_count);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
